[src/ofih_pkg.sv]
`default_nettype none
package ofih_pkg;

    // Window and field geometry
    localparam int WINDOW        = 2048;
    localparam int AW            = $clog2(WINDOW);
    localparam int CW            = AW + 1;
    localparam int MAX_LAG_LIMIT = 10;
    localparam int MIN_SAMPLES   = 3;
    localparam int LAG_W         = 4;
    localparam int DEPTH_W       = 24;
    localparam int OFI_W         = DEPTH_W + 2;
    localparam int RET_W         = DEPTH_W + 1;
    localparam int PROD_W        = 2 * OFI_W;
    localparam int ACC_W         = PROD_W + AW;
    localparam int SUM_W         = OFI_W + AW + 1;
    localparam int NN_W          = 2 * CW - 1;

    // Wide arithmetic
    localparam int FRAC_BITS = 24;
    localparam int BW        = 128;
    localparam int MBW       = 40;
    localparam int CORR_W    = 32;
    localparam int QW        = CORR_W - 1;
    localparam int KW        = $clog2(QW + 1);

    localparam logic [LAG_W-1:0] MAX_LAG_RESET = LAG_W'(10);
    localparam logic signed [CORR_W-1:0] CORR_MAX = {1'b0, {QW{1'b1}}};
    localparam logic signed [CORR_W-1:0] CORR_MIN = {1'b1, {QW{1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PASS,
        ST_ALU_GO,
        ST_ALU_WAIT,
        ST_LAG,
        ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        SP_NSQ,
        SP_SOSO,
        SP_NN,
        SP_SRSO,
        SP_P,
        SP_SORL,
        SP_SORLN,
        SP_SROL,
        SP_SROLN,
        SP_SRSOC,
        SP_NCNT,
        SP_DEN,
        SP_DIV,
        SP_C1C,
        SP_C2C
    } step_t;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

endpackage
`default_nettype wire

[src/ofih_channels.sv]
`default_nettype none
interface ofih_sample_if;
    import ofih_pkg::*;
    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] bid_depth_total;
    logic [DEPTH_W-1:0] ask_depth_total;
    logic [DEPTH_W-1:0] close_ticks;
    logic               restart;

    modport source (output valid, bid_depth_total, ask_depth_total, close_ticks, restart,
                    input ready);
    modport sink (input valid, bid_depth_total, ask_depth_total, close_ticks, restart,
                  output ready);
endinterface

interface ofih_result_if;
    import ofih_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [LAG_W-1:0]         lag;
    logic signed [CORR_W-1:0] correlation;
    logic [LAG_W-1:0]         half_life;
    logic                     last;

    modport source (output valid, lag, correlation, half_life, last, input ready);
    modport sink (input valid, lag, correlation, half_life, last, output ready);
endinterface

interface ofih_cfg_if;
    import ofih_pkg::*;
    logic             valid;
    logic             ready;
    logic [LAG_W-1:0] max_lag;

    modport source (output valid, max_lag, input ready);
    modport sink (input valid, max_lag, output ready);
endinterface
`default_nettype wire

[src/order_flow_impact_halflife.sv]
`default_nettype none
// Throughput: one item at a time; set by the window walks through the two RAM read ports
//   and by the shared bit-serial multiply/divide unit (one multiplier bit or one quotient bit a cycle).
// Reset: clears control, counters, history flag and max_lag (to 10); RAMs, last totals kept.
module order_flow_impact_halflife (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ofih_sample_if.sink  sample,
    ofih_result_if.source result,
    ofih_cfg_if.sink     cfg
);
    import ofih_pkg::*;

    state_t state_reg, state_next;
    step_t  step_reg;

    // Item bookkeeping
    logic [LAG_W-1:0]   max_lag_reg;
    logic [LAG_W-1:0]   k_reg;
    logic [LAG_W-1:0]   lag_reg;
    logic [LAG_W-1:0]   hl_reg;
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      ptr_reg;
    logic [DEPTH_W-1:0] prev_bid_reg;
    logic [DEPTH_W-1:0] prev_ask_reg;
    logic [DEPTH_W-1:0] prev_close_reg;
    logic               have_prev_reg;

    // Window walk pipeline
    logic [CW-1:0]              pass_idx_reg;
    logic                       issue_reg;
    logic                       v1_reg;
    logic                       v2_reg;
    logic                       stats_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [OFI_W-1:0]    o_d_reg;
    logic signed [RET_W-1:0]    r_d_reg;
    logic signed [ACC_W-1:0]    acc_p_reg;
    logic signed [SUM_W-1:0]    acc_o_reg;
    logic signed [SUM_W-1:0]    acc_r_reg;

    // Sums
    logic signed [SUM_W-1:0] so_reg, sr_reg, rl_reg, ol_reg;
    logic signed [ACC_W-1:0] sq_reg, p_reg;
    logic [NN_W-1:0]         nn_reg;
    logic signed [BW-1:0]    t1_reg, v_reg, srso_reg, c_reg, c1_reg;
    logic [BW-1:0]           den_reg;
    logic signed [CORR_W-1:0] corr_reg;
    logic                    halved_reg;

    // Output register
    logic                     out_valid_reg;
    logic [LAG_W-1:0]         out_lag_reg;
    logic signed [CORR_W-1:0] out_corr_reg;
    logic [LAG_W-1:0]         out_hl_reg;
    logic                     out_last_reg;

    logic accept;
    logic signed [OFI_W-1:0] bid_diff, ask_diff;
    logic [OFI_W-1:0]  ofi_wdata, ofi_rdata;
    logic [RET_W-1:0]  ret_wdata, ret_rdata;
    logic [AW-1:0]     wr_addr, ret_raddr, ofi_raddr;
    logic [LAG_W-1:0]  pass_lag;
    logic              pass_done;
    logic              pass_launch;
    logic signed [OFI_W-1:0] o_rd, mul_y;
    logic [CW-1:0]     cnt, cnt1;
    logic              lag_in_data;
    logic              out_free;
    logic              out_load;
    logic              last_lag;
    logic [LAG_W-1:0]  hl_new;
    logic [LAG_W-1:0]  k_clamped;

    alu_cmd_t                 alu_cmd;
    alu_stat_t                alu_stat;
    logic signed [BW-1:0]     alu_a;
    logic signed [MBW-1:0]    alu_b;
    logic signed [BW-1:0]     alu_prod;
    logic signed [CORR_W-1:0] alu_quot;
    logic signed [BW-1:0]     diff;
    logic                     v_pos;

    assign accept = sample.valid && sample.ready;

    // Imbalance and close difference of the incoming bar
    assign bid_diff  = $signed({2'b00, sample.bid_depth_total}) - $signed({2'b00, prev_bid_reg});
    assign ask_diff  = $signed({2'b00, sample.ask_depth_total}) - $signed({2'b00, prev_ask_reg});
    assign ofi_wdata = (have_prev_reg && !sample.restart) ? $unsigned(bid_diff - ask_diff) : '0;
    assign ret_wdata = have_prev_reg
                       ? $unsigned($signed({1'b0, sample.close_ticks})
                                   - $signed({1'b0, prev_close_reg}))
                       : '0;
    // Count low bits are zero once the window is full, so this lands on the oldest slot
    assign wr_addr   = ptr_reg + count_reg[AW-1:0];

    // Lag pass reads return[i] against imbalance[i - lag]; the stats pass uses lag zero
    assign pass_lag  = stats_reg ? '0 : lag_reg;
    assign ret_raddr = ptr_reg + pass_idx_reg[AW-1:0];
    assign ofi_raddr = ret_raddr - AW'(pass_lag);
    assign pass_done = !issue_reg && !v1_reg && !v2_reg;

    assign o_rd  = $signed(ofi_rdata);
    assign mul_y = stats_reg ? o_rd : OFI_W'($signed(ret_rdata));

    assign cnt         = count_reg - CW'(lag_reg);
    assign cnt1        = count_reg - 1'b1;
    assign lag_in_data = CW'(lag_reg) < count_reg;
    assign out_free    = !out_valid_reg || result.ready;
    assign last_lag    = (lag_reg == k_reg);
    assign hl_new      = (halved_reg && hl_reg == k_reg) ? lag_reg : hl_reg;
    assign diff        = t1_reg - alu_prod;
    assign v_pos       = !diff[BW-1] && (diff != '0);

    assign k_clamped = (max_lag_reg == '0) ? LAG_W'(1)
                     : (max_lag_reg > LAG_W'(MAX_LAG_LIMIT)) ? LAG_W'(MAX_LAG_LIMIT)
                     : max_lag_reg;

    ofih_ram #(.WIDTH(OFI_W), .DEPTH(WINDOW)) u_ofi_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (wr_addr),
        .wdata (ofi_wdata),
        .raddr (ofi_raddr),
        .rdata (ofi_rdata)
    );

    ofih_ram #(.WIDTH(RET_W), .DEPTH(WINDOW)) u_ret_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (wr_addr),
        .wdata (ret_wdata),
        .raddr (ret_raddr),
        .rdata (ret_rdata)
    );

    ofih_alu u_alu (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (alu_cmd),
        .a        (alu_a),
        .b        (alu_b),
        .den      (den_reg),
        .stat     (alu_stat),
        .product  (alu_prod),
        .quotient (alu_quot)
    );

    // Operand select for each step of the covariance algebra
    always_comb
    begin
        alu_a = '0;
        alu_b = '0;
        unique case (step_reg) inside
            SP_NSQ:
            begin
                alu_a = BW'(sq_reg);
                alu_b = MBW'(count_reg);
            end
            SP_SOSO:
            begin
                alu_a = BW'(so_reg);
                alu_b = MBW'(so_reg);
            end
            SP_NN:
            begin
                alu_a = BW'(count_reg);
                alu_b = MBW'(count_reg);
            end
            SP_SRSO:
            begin
                alu_a = BW'(sr_reg);
                alu_b = MBW'(so_reg);
            end
            SP_P:
            begin
                alu_a = BW'(p_reg);
                alu_b = MBW'(nn_reg);
            end
            SP_SORL:
            begin
                alu_a = BW'(rl_reg);
                alu_b = MBW'(so_reg);
            end
            SP_SORLN, SP_SROLN:
            begin
                alu_a = t1_reg;
                alu_b = MBW'(count_reg);
            end
            SP_SROL:
            begin
                alu_a = BW'(sr_reg);
                alu_b = MBW'(ol_reg);
            end
            SP_SRSOC:
            begin
                alu_a = srso_reg;
                alu_b = MBW'(cnt);
            end
            SP_NCNT:
            begin
                alu_a = BW'(count_reg);
                alu_b = MBW'(cnt);
            end
            SP_DEN:
            begin
                alu_a = v_reg;
                alu_b = $signed(t1_reg[MBW-1:0]);
            end
            SP_DIV:
            begin
                alu_a = c_reg;
            end
            SP_C1C:
            begin
                alu_a = c1_reg;
                alu_b = MBW'(cnt);
            end
            SP_C2C:
            begin
                alu_a = c_reg;
                alu_b = MBW'({cnt1, 1'b0});
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = (count_reg < CW'(MIN_SAMPLES)) ? ST_IDLE : ST_PASS;
            end
            ST_PASS:
            begin
                if (pass_done)
                begin
                    state_next = ST_ALU_GO;
                end
            end
            ST_ALU_GO:
            begin
                state_next = ST_ALU_WAIT;
            end
            ST_ALU_WAIT:
            begin
                if (alu_stat.done)
                begin
                    case (step_reg)
                        SP_SOSO: state_next = v_pos ? ST_ALU_GO : ST_IDLE;
                        SP_SRSO: state_next = ST_LAG;
                        SP_C2C:  state_next = ST_EMIT;
                        default: state_next = ST_ALU_GO;
                    endcase
                end
            end
            ST_LAG:
            begin
                state_next = lag_in_data ? ST_PASS : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last_lag ? ST_IDLE : ST_LAG;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control strobes
    always_comb
    begin
        sample.ready = (state_reg == ST_IDLE);
        cfg.ready    = 1'b1;
        pass_launch  = ((state_reg == ST_CHECK) && (count_reg >= CW'(MIN_SAMPLES)))
                    || ((state_reg == ST_LAG) && lag_in_data);
        out_load     = (state_reg == ST_EMIT) && out_free;
        alu_cmd.start = (state_reg == ST_ALU_GO);
        alu_cmd.op    = (step_reg == SP_DIV) ? ALU_DIV : ALU_MUL;
    end

    assign result.valid       = out_valid_reg;
    assign result.lag         = out_lag_reg;
    assign result.correlation = out_corr_reg;
    assign result.half_life   = out_hl_reg;
    assign result.last        = out_last_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_lag_reg   <= MAX_LAG_RESET;
            count_reg     <= '0;
            ptr_reg       <= '0;
            have_prev_reg <= 1'b0;
            issue_reg     <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                max_lag_reg <= cfg.max_lag;
            end
            if (accept)
            begin
                have_prev_reg <= 1'b1;
                // Grow until full, then advance the oldest slot
                if (count_reg != CW'(WINDOW))
                begin
                    count_reg <= count_reg + 1'b1;
                end
                else
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
            end
            v1_reg <= issue_reg;
            v2_reg <= v1_reg;
            if (pass_launch)
            begin
                issue_reg <= 1'b1;
            end
            else if (issue_reg && (pass_idx_reg == cnt1))
            begin
                issue_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prev_bid_reg   <= sample.bid_depth_total;
            prev_ask_reg   <= sample.ask_depth_total;
            prev_close_reg <= sample.close_ticks;
        end

        if (state_reg == ST_CHECK)
        begin
            k_reg <= k_clamped;
        end

        // Window walk: issue, read, multiply, accumulate
        if (pass_launch)
        begin
            stats_reg    <= (state_reg == ST_CHECK);
            pass_idx_reg <= (state_reg == ST_CHECK) ? '0 : CW'(lag_reg);
            acc_p_reg    <= '0;
            acc_o_reg    <= '0;
            acc_r_reg    <= '0;
        end
        else if (issue_reg)
        begin
            pass_idx_reg <= pass_idx_reg + 1'b1;
        end
        if (v1_reg)
        begin
            prod_reg <= o_rd * mul_y;
            o_d_reg  <= o_rd;
            r_d_reg  <= $signed(ret_rdata);
        end
        if (v2_reg)
        begin
            acc_p_reg <= acc_p_reg + ACC_W'(prod_reg);
            acc_o_reg <= acc_o_reg + SUM_W'(o_d_reg);
            acc_r_reg <= acc_r_reg + SUM_W'(r_d_reg);
        end

        if ((state_reg == ST_PASS) && pass_done)
        begin
            if (stats_reg)
            begin
                so_reg   <= acc_o_reg;
                sr_reg   <= acc_r_reg;
                sq_reg   <= acc_p_reg;
                step_reg <= SP_NSQ;
            end
            else
            begin
                p_reg    <= acc_p_reg;
                rl_reg   <= acc_r_reg;
                ol_reg   <= acc_o_reg;
                step_reg <= SP_P;
            end
        end

        // Write back each result and advance the step; SP_SRSO and SP_C2C leave the step as it is
        if ((state_reg == ST_ALU_WAIT) && alu_stat.done)
        begin
            case (step_reg)
                SP_NSQ:
                begin
                    t1_reg   <= alu_prod;
                    step_reg <= SP_SOSO;
                end
                SP_SOSO:
                begin
                    v_reg    <= diff;
                    step_reg <= SP_NN;
                end
                SP_NN:
                begin
                    nn_reg   <= alu_prod[NN_W-1:0];
                    step_reg <= SP_SRSO;
                end
                SP_SRSO:
                begin
                    srso_reg <= alu_prod;
                    lag_reg  <= LAG_W'(1);
                    hl_reg   <= k_reg;
                end
                SP_P:
                begin
                    c_reg    <= alu_prod;
                    step_reg <= SP_SORL;
                end
                SP_SORL:
                begin
                    t1_reg   <= alu_prod;
                    step_reg <= SP_SORLN;
                end
                SP_SORLN:
                begin
                    c_reg    <= c_reg - alu_prod;
                    step_reg <= SP_SROL;
                end
                SP_SROL:
                begin
                    t1_reg   <= alu_prod;
                    step_reg <= SP_SROLN;
                end
                SP_SROLN:
                begin
                    c_reg    <= c_reg - alu_prod;
                    step_reg <= SP_SRSOC;
                end
                SP_SRSOC:
                begin
                    c_reg <= c_reg + alu_prod;
                    if (lag_reg == LAG_W'(1))
                    begin
                        c1_reg <= c_reg + alu_prod;
                    end
                    step_reg <= SP_NCNT;
                end
                SP_NCNT:
                begin
                    t1_reg   <= alu_prod;
                    step_reg <= SP_DEN;
                end
                SP_DEN:
                begin
                    den_reg  <= $unsigned(alu_prod);
                    step_reg <= SP_DIV;
                end
                SP_DIV:
                begin
                    corr_reg <= alu_quot;
                    step_reg <= SP_C1C;
                end
                SP_C1C:
                begin
                    t1_reg   <= alu_prod;
                    step_reg <= SP_C2C;
                end
                SP_C2C:
                begin
                    // c / cnt <= c1 / (2 * cnt1), cross-multiplied
                    halved_reg <= !diff[BW-1];
                end
                default:
                begin
                    step_reg <= step_reg;
                end
            endcase
        end

        // Lag past the data: value zero, halved when the lag-1 value is not negative
        if ((state_reg == ST_LAG) && !lag_in_data)
        begin
            corr_reg   <= '0;
            halved_reg <= !c1_reg[BW-1];
        end

        if (out_load)
        begin
            out_lag_reg  <= lag_reg;
            out_corr_reg <= corr_reg;
            out_hl_reg   <= last_lag ? hl_new : '0;
            out_last_reg <= last_lag;
            hl_reg       <= hl_new;
            lag_reg      <= lag_reg + 1'b1;
        end
    end

    a_hl_last: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.last |->
            (result.half_life != '0) && (result.half_life <= LAG_W'(MAX_LAG_LIMIT)))
        else $error("half-life out of range on final beat");

    a_hl_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.last |-> result.half_life == '0)
        else $error("half-life set on a non-final beat");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(WINDOW))
        else $error("sample count exceeds window");

    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(ptr_reg) |-> $past(count_reg) == CW'(WINDOW))
        else $error("oldest pointer moved before window filled");

    a_alu: assert property (@(posedge clk) disable iff (!rst_n)
        alu_cmd.start |-> !alu_stat.busy)
        else $error("arithmetic unit started while busy");
endmodule
`default_nettype wire

[src/ofih_ram.sv]
`default_nettype none
module ofih_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[src/ofih_alu.sv]
`default_nettype none
module ofih_alu (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire ofih_pkg::alu_cmd_t                   cmd,
    input  wire logic signed [ofih_pkg::BW-1:0]       a,
    input  wire logic signed [ofih_pkg::MBW-1:0]      b,
    input  wire logic [ofih_pkg::BW-1:0]              den,
    output ofih_pkg::alu_stat_t                       stat,
    output logic signed [ofih_pkg::BW-1:0]            product,
    output logic signed [ofih_pkg::CORR_W-1:0]        quotient
);
    import ofih_pkg::*;

    logic [BW-1:0]  acc_reg;
    logic [BW-1:0]  opd_reg;
    logic [MBW-1:0] mb_reg;
    logic           neg_reg;
    logic           busy_reg;
    logic           done_reg;
    alu_op_t        op_reg;
    logic [KW-1:0]  k_reg;
    logic [QW-1:0]  q_reg;
    logic           sat_reg;

    logic [BW-1:0]  a_mag;
    logic [MBW-1:0] b_mag;
    logic [BW-1:0]  addend;
    logic           sub;
    logic [BW:0]    sum;

    assign a_mag  = a[BW-1] ? $unsigned(-a) : $unsigned(a);
    assign b_mag  = b[MBW-1] ? $unsigned(-b) : $unsigned(b);
    // Divide steps subtract through the same adder
    assign sub    = (op_reg == ALU_DIV);
    assign addend = sub ? ~opd_reg : opd_reg;
    assign sum    = {1'b0, acc_reg} + {1'b0, addend} + {{BW{1'b0}}, sub};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (op_reg == ALU_MUL)
                begin
                    if (mb_reg == '0)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
                else if (k_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg <= cmd.op;
            if (cmd.op == ALU_MUL)
            begin
                neg_reg <= a[BW-1] ^ b[MBW-1];
                acc_reg <= '0;
                opd_reg <= a_mag;
                mb_reg  <= b_mag;
            end
            else
            begin
                neg_reg <= a[BW-1];
                acc_reg <= a_mag << FRAC_BITS;
                opd_reg <= den << QW;
                k_reg   <= KW'(QW);
                q_reg   <= '0;
                sat_reg <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == ALU_MUL)
            begin
                if (mb_reg != '0)
                begin
                    if (mb_reg[0])
                    begin
                        acc_reg <= sum[BW-1:0];
                    end
                    opd_reg <= opd_reg << 1;
                    mb_reg  <= mb_reg >> 1;
                end
            end
            else
            begin
                // carry out set: remainder covers the shifted divisor
                if (sum[BW])
                begin
                    acc_reg <= sum[BW-1:0];
                    if (k_reg == KW'(QW))
                    begin
                        sat_reg <= 1'b1;
                    end
                    else
                    begin
                        q_reg[k_reg] <= 1'b1;
                    end
                end
                opd_reg <= opd_reg >> 1;
                if (k_reg != '0)
                begin
                    k_reg <= k_reg - 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        stat.busy = busy_reg;
        stat.done = done_reg;
        product   = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);
        if (sat_reg)
        begin
            quotient = neg_reg ? CORR_MIN : CORR_MAX;
        end
        else
        begin
            quotient = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        end
    end
endmodule
`default_nettype wire
